>>> rtl/core/svf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svf_pkg: shared types, constants and helpers of the state variable filter
// Widths of the fixed-point formats, register map and the saturation helper.
// ----------------------------------------------------------------------------
package svf_pkg;

	// sample and coefficient formats
	localparam int SAMPLE_BITS    = 24;
	localparam int COEF_FRAC_BITS = 24;
	localparam int STATE_FRAC     = 23;
	localparam int Q_W            = 32;  // Q9.23 states and outputs
	localparam int COEF_W         = 32;  // Q8.24 coefficients
	localparam int NORM_W         = 25;  // Q1.24 normalizer

	// digit-serial multiplier geometry
	localparam int DIGIT_BITS = 4;
	localparam int NDIG       = COEF_W / DIGIT_BITS;
	localparam int CNT_W      = $clog2(NDIG);
	localparam int HI_W       = Q_W + DIGIT_BITS + 2;
	localparam int PROD_W     = 2 * Q_W;
	localparam int RND_W      = PROD_W - COEF_FRAC_BITS + 1;
	localparam int WIDE_W     = RND_W + 3;

	// sample alignment to Q9.23
	localparam int ALIGN = STATE_FRAC - (SAMPLE_BITS - 1);
	localparam int LSH   = (ALIGN > 0) ? ALIGN : 0;
	localparam int RSH   = (ALIGN < 0) ? -ALIGN : 1;

	// register map
	localparam int ADDR_W = 4;
	localparam logic [1:0] REG_CUTOFF = 2'd0;
	localparam logic [1:0] REG_DAMP   = 2'd1;
	localparam logic [1:0] REG_NORM   = 2'd2;

	localparam logic [COEF_W-1:0] GAIN_RST = 32'h0000_0000;
	localparam logic [COEF_W-1:0] DAMP_RST = 32'h0100_0000;
	localparam logic [NORM_W-1:0] NORM_RST = 25'h100_0000;

	typedef logic signed [WIDE_W-1:0] wide_t;

	localparam wide_t Q_MAX_W = wide_t'(32'sh7FFF_FFFF);
	localparam wide_t Q_MIN_W = wide_t'(32'sh8000_0000);

	typedef struct packed {
		logic [COEF_W-1:0] gain;
		logic [COEF_W-1:0] damp;
		logic [NORM_W-1:0] norm;
	} coef_t;

	typedef struct packed {
		logic                    start;
		logic signed [Q_W-1:0]   a;
		logic [COEF_W-1:0]       c;
	} mul_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [RND_W-1:0] prod;
	} mul_rsp_t;

	typedef struct packed {
		logic signed [Q_W-1:0] lp;
		logic signed [Q_W-1:0] hp;
		logic signed [Q_W-1:0] bp;
	} res_t;

	// clamp to signed Q9.23
	function automatic logic signed [Q_W-1:0] sat_q(input wide_t v);
		logic signed [Q_W-1:0] r;
		if (v > Q_MAX_W)
			r = 32'sh7FFF_FFFF;
		else if (v < Q_MIN_W)
			r = 32'sh8000_0000;
		else
			r = v[Q_W-1:0];
		return r;
	endfunction

	// bring a sample to Q9.23: left shift, or rounded right shift for wide samples
	function automatic logic signed [Q_W-1:0] align_sample(
		input logic signed [SAMPLE_BITS-1:0] s
	);
		logic signed [Q_W:0] ext;
		logic signed [Q_W:0] biased;
		ext    = (Q_W + 1)'(s);
		biased = ext + (Q_W + 1)'(1 <<< (RSH - 1));
		if (SAMPLE_BITS <= STATE_FRAC + 1)
			return Q_W'(ext <<< LSH);
		else
			return Q_W'(biased >>> RSH);
	endfunction

endpackage

>>> rtl/core/svf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svf_if: valid/ready channels of the state variable filter
// One interface carries input samples, the other carries filter results.
// ----------------------------------------------------------------------------
interface svf_sample_if import svf_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface svf_result_if import svf_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic signed [Q_W-1:0] lowpass_out;
	logic signed [Q_W-1:0] highpass_out;
	logic signed [Q_W-1:0] bandpass_out;

	modport source (
		output valid, output lowpass_out, output highpass_out, output bandpass_out,
		input ready
	);
	modport sink (
		input valid, input lowpass_out, input highpass_out, input bandpass_out,
		output ready
	);
endinterface

>>> rtl/core/svf_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svf_regs: coefficient register file
// APB-style write/read access to cutoff gain, twice damping and normalizer.
// ----------------------------------------------------------------------------
module svf_regs import svf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output coef_t             coef
);

	logic [COEF_W-1:0] gain_q;
	logic [COEF_W-1:0] damp_q;
	logic [NORM_W-1:0] norm_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RST;
			damp_q <= DAMP_RST;
			norm_q <= NORM_RST;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_CUTOFF: gain_q <= pwdata;
				REG_DAMP:   damp_q <= pwdata;
				REG_NORM:   norm_q <= pwdata[NORM_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (paddr[3:2])
			REG_CUTOFF: prdata = gain_q;
			REG_DAMP:   prdata = damp_q;
			REG_NORM:   prdata = 32'(norm_q);
			default:    prdata = '0;
		endcase
	end

	assign coef.gain = gain_q;
	assign coef.damp = damp_q;
	assign coef.norm = norm_q;

endmodule

>>> rtl/core/svf_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svf_mul: digit-serial coefficient multiplier
// Signed Q9.23 value times unsigned coefficient, one 4-bit coefficient digit
// per cycle, LSB first; the product is rounded half up by COEF_FRAC_BITS.
// ----------------------------------------------------------------------------
module svf_mul import svf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	logic                    busy_q;
	logic                    done_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [Q_W-1:0]   v_q;
	logic [COEF_W-1:0]       c_q;
	logic signed [HI_W-1:0]  hi_q;
	logic [Q_W-1:0]          lo_q;

	logic signed [DIGIT_BITS:0] digit;
	logic signed [HI_W-1:0]     sum;
	logic [PROD_W-1:0]          prod_full;

	// partial product of the current digit
	assign digit = $signed({1'b0, c_q[DIGIT_BITS-1:0]});
	assign sum   = hi_q + v_q * digit;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(NDIG - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// shift-add datapath: low product bits shift out into lo_q
	always_ff @(posedge clk) begin
		if (req.start) begin
			v_q  <= req.a;
			c_q  <= req.c;
			hi_q <= '0;
		end else if (busy_q) begin
			hi_q <= sum >>> DIGIT_BITS;
			lo_q <= {sum[DIGIT_BITS-1:0], lo_q[Q_W-1:DIGIT_BITS]};
			c_q  <= c_q >> DIGIT_BITS;
		end
	end

	// rounded product
	assign prod_full = {hi_q[Q_W-1:0], lo_q};
	assign rsp.done  = done_q;
	assign rsp.prod  = RND_W'($signed(prod_full[PROD_W-1:COEF_FRAC_BITS]))
		+ RND_W'({1'b0, prod_full[COEF_FRAC_BITS-1]});

endmodule

>>> rtl/core/svf_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svf_seq: filter sequencer and integrator state
// Walks one sample through the four coefficient products on the shared
// multiplier and updates both trapezoidal integrators.
// ----------------------------------------------------------------------------
module svf_seq import svf_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  coef_t                         coef,
	input  logic                          smp_valid,
	output logic                          smp_ready,
	input  logic signed [SAMPLE_BITS-1:0] smp,
	output mul_req_t                      mreq,
	input  mul_rsp_t                      mrsp,
	output logic                          res_valid,
	input  logic                          res_ready,
	output res_t                          res
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_FB   = 3'd1;  // (2R+g)*s1
	localparam logic [2:0] ST_NORM = 3'd2;  // t*d
	localparam logic [2:0] ST_BAND = 3'd3;  // g*hp
	localparam logic [2:0] ST_LOW  = 3'd4;  // g*bp
	localparam logic [2:0] ST_UPD  = 3'd5;  // integrator update
	localparam logic [2:0] ST_DONE = 3'd6;  // result waits

	logic [2:0]              state_q;
	logic signed [Q_W-1:0]   s1_q;
	logic signed [Q_W-1:0]   s2_q;
	logic signed [Q_W-1:0]   x_q;
	logic signed [Q_W-1:0]   hp_q;
	logic signed [Q_W-1:0]   bp_q;
	logic signed [Q_W-1:0]   lp_q;
	logic signed [RND_W-1:0] v1_q;
	logic signed [RND_W-1:0] v2_q;

	logic [COEF_W:0]       fb_sum;
	logic [COEF_W-1:0]     fb;
	logic signed [Q_W-1:0] t_n;
	logic signed [Q_W-1:0] hp_n;
	logic signed [Q_W-1:0] bp_n;
	logic signed [Q_W-1:0] lp_n;

	// feedback gain 2R+g, saturated to 32 unsigned bits
	assign fb_sum = {1'b0, coef.damp} + {1'b0, coef.gain};
	assign fb     = fb_sum[COEF_W] ? '1 : fb_sum[COEF_W-1:0];

	// per-step results from the multiplier output
	assign t_n  = sat_q(wide_t'(x_q) - wide_t'(mrsp.prod) - wide_t'(s2_q));
	assign hp_n = sat_q(wide_t'(mrsp.prod));
	assign bp_n = sat_q(wide_t'(mrsp.prod) + wide_t'(s1_q));
	assign lp_n = sat_q(wide_t'(mrsp.prod) + wide_t'(s2_q));

	// multiplier launch
	always_comb begin
		mreq.start = 1'b0;
		mreq.a     = s1_q;
		mreq.c     = fb;
		unique case (state_q)
			ST_IDLE: mreq.start = smp_valid;
			ST_FB: begin
				mreq.start = mrsp.done;
				mreq.a     = t_n;
				mreq.c     = COEF_W'(coef.norm);
			end
			ST_NORM: begin
				mreq.start = mrsp.done;
				mreq.a     = hp_n;
				mreq.c     = coef.gain;
			end
			ST_BAND: begin
				mreq.start = mrsp.done;
				mreq.a     = bp_n;
				mreq.c     = coef.gain;
			end
			default: mreq.start = 1'b0;
		endcase
	end

	// sequencer and integrator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			s1_q    <= '0;
			s2_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (smp_valid) state_q <= ST_FB;
				ST_FB:   if (mrsp.done) state_q <= ST_NORM;
				ST_NORM: if (mrsp.done) state_q <= ST_BAND;
				ST_BAND: if (mrsp.done) state_q <= ST_LOW;
				ST_LOW:  if (mrsp.done) state_q <= ST_UPD;
				ST_UPD: begin
					s1_q    <= sat_q(wide_t'(bp_q) + wide_t'(v1_q));
					s2_q    <= sat_q(wide_t'(lp_q) + wide_t'(v2_q));
					state_q <= ST_DONE;
				end
				ST_DONE: if (res_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working values of the current sample
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && smp_valid)
			x_q <= align_sample(smp);
		if (state_q == ST_NORM && mrsp.done)
			hp_q <= hp_n;
		if (state_q == ST_BAND && mrsp.done) begin
			bp_q <= bp_n;
			v1_q <= mrsp.prod;
		end
		if (state_q == ST_LOW && mrsp.done) begin
			lp_q <= lp_n;
			v2_q <= mrsp.prod;
		end
	end

	assign smp_ready = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res.lp    = lp_q;
	assign res.hp    = hp_q;
	assign res.bp    = bp_q;

endmodule

>>> rtl/core/tpt_state_variable_filter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpt_state_variable_filter_unit: TPT state variable filter, fixed point
// One signed sample word in on sample_ch, one word with lowpass, highpass
// and bandpass (Q9.23, saturated) out on result_ch; valid/ready handshakes.
// Coefficients g, 2R and d are written over the APB-style port at byte
// addresses 0x0, 0x4 and 0x8; the user must write them only while the
// filter is idle, since the block itself does not enforce it.
// The single digit-serial multiplier forms the four coefficient products
// in turn (4-bit digits), followed by an integrator update, a handoff and
// the idle state in which the next sample is accepted; a new sample is
// taken only after the last result has been handed off.
// The output register holds a finished word while the receiver stalls; the
// next sample is accepted and processed meanwhile and waits in the
// sequencer until the output register frees up.
// Reset clears both integrators to zero, sets g=0, 2R=1.0, d=1.0, and
// empties the output register.
// ----------------------------------------------------------------------------
module tpt_state_variable_filter_unit import svf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	svf_sample_if.sink        sample_ch,
	svf_result_if.source      result_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	coef_t    coef;
	mul_req_t mreq;
	mul_rsp_t mrsp;
	logic     res_valid;
	logic     res_ready;
	res_t     res;

	logic     out_valid_q;
	res_t     out_q;

	svf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.coef    (coef)
	);

	svf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	svf_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef      (coef),
		.smp_valid (sample_ch.valid),
		.smp_ready (sample_ch.ready),
		.smp       (sample_ch.sample_in),
		.mreq      (mreq),
		.mrsp      (mrsp),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register: loads when empty or being drained
	assign res_ready = !out_valid_q || result_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_valid && res_ready)
			out_valid_q <= 1'b1;
		else if (result_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready)
			out_q <= res;
	end

	assign result_ch.valid        = out_valid_q;
	assign result_ch.lowpass_out  = out_q.lp;
	assign result_ch.highpass_out = out_q.hp;
	assign result_ch.bandpass_out = out_q.bp;

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for tpt_state_variable_filter_unit
// Streams signed samples through the filter and checks every lowpass,
// highpass and bandpass word against a fixed-point filter model kept in a
// small scoreboard class. Coefficients are rewritten over the APB port
// between bursts, with realistic, random and extreme settings, while both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
	import svf_pkg::*;

	localparam int  HALF_PERIOD = 10;
	localparam int  IDLE_LIMIT  = 5000;   // cycles with no word moving
	localparam int  SETTLE      = 60;     // a bit over one sample latency
	localparam int  REPORT_MAX  = 10;
	localparam int  PHASES      = 8;
	localparam int  PHASE_ITEMS = 75;
	localparam int  IN_SHIFT    = STATE_FRAC - (SAMPLE_BITS - 1);

	localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic [COEF_W-1:0] COEF_ONE = 32'h0100_0000;

	// filter model: coefficients, integrators and the queue of pending words
	class filter_scoreboard;
		logic [COEF_W-1:0] gain;
		logic [COEF_W-1:0] damp;
		logic [NORM_W-1:0] norm;
		longint            integ1;
		longint            integ2;
		res_t              pending[$];
		int                errors;

		function new();
			gain   = GAIN_RST;
			damp   = DAMP_RST;
			norm   = NORM_RST;
			integ1 = 0;
			integ2 = 0;
			errors = 0;
		endfunction

		function void set_coef(input logic [1:0] idx, input logic [31:0] v);
			case (idx)
				REG_CUTOFF: gain = v;
				REG_DAMP:   damp = v;
				REG_NORM:   norm = v[NORM_W-1:0];
				default: ;
			endcase
		endfunction

		// floor((p + half) / 2^f): round half toward plus infinity
		function longint round_shift(input logic signed [95:0] p, input int f);
			if (f == 0)
				return longint'(p);
			return longint'((p + (96'sd1 <<< (f - 1))) >>> f);
		endfunction

		function longint coef_mul(input longint v, input logic [31:0] c);
			logic signed [95:0] pv;
			logic signed [95:0] pc;
			pv = v;
			pc = {64'd0, c};
			return round_shift(pv * pc, COEF_FRAC_BITS);
		endfunction

		function longint clamp_q(input longint v);
			if (v > longint'(32'sh7FFF_FFFF))
				return longint'(32'sh7FFF_FFFF);
			if (v < longint'(32'sh8000_0000))
				return longint'(32'sh8000_0000);
			return v;
		endfunction

		// one accepted sample: advance the integrators, queue the output word
		function void note_sample(input logic signed [SAMPLE_BITS-1:0] s);
			longint      x, t, hp, v1, bp, v2, lp;
			logic [32:0] fb_sum;
			logic [31:0] fb;
			res_t        r;
			x = longint'(s);
			if (IN_SHIFT >= 0)
				x = x <<< IN_SHIFT;
			else
				x = round_shift(96'(x), -IN_SHIFT);
			fb_sum = {1'b0, damp} + {1'b0, gain};
			fb = fb_sum[32] ? 32'hFFFF_FFFF : fb_sum[31:0];
			t  = clamp_q(x - coef_mul(integ1, fb) - integ2);
			hp = clamp_q(coef_mul(t, {7'd0, norm}));
			v1 = coef_mul(hp, gain);
			bp = clamp_q(v1 + integ1);
			integ1 = clamp_q(bp + v1);
			v2 = coef_mul(bp, gain);
			lp = clamp_q(v2 + integ2);
			integ2 = clamp_q(lp + v2);
			r.lp = lp[Q_W-1:0];
			r.hp = hp[Q_W-1:0];
			r.bp = bp[Q_W-1:0];
			pending.push_back(r);
		endfunction

		function void field_check(input string name, input logic signed [Q_W-1:0] exp_v,
			input logic signed [Q_W-1:0] got_v);
			if (exp_v !== got_v) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("%0t: %s mismatch, expected %0d, got %0d",
						$realtime, name, exp_v, got_v);
			end
		endfunction

		function void check_result(input logic signed [Q_W-1:0] lp,
			input logic signed [Q_W-1:0] hp, input logic signed [Q_W-1:0] bp);
			res_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("%0t: output word with none pending (lp %0d hp %0d bp %0d)",
						$realtime, lp, hp, bp);
				return;
			end
			e = pending.pop_front();
			field_check("lowpass", e.lp, lp);
			field_check("highpass", e.hp, hp);
			field_check("bandpass", e.bp, bp);
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	bit                calm;       // no gaps or stalls in this burst
	int                idle_cycles;
	int                ready_hold;

	filter_scoreboard sb = new();

	svf_sample_if smp();
	svf_result_if res();

	tpt_state_variable_filter_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (smp),
		.result_ch (res),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	// receiver: alternate ready stretches and stalls
	always @(negedge clk) begin
		if (ready_hold > 0) begin
			ready_hold--;
		end else if (calm || $urandom_range(0, 9) < 6) begin
			res.ready  <= 1'b1;
			ready_hold = $urandom_range(1, 12);
		end else begin
			res.ready  <= 1'b0;
			ready_hold = gap_len();
		end
	end

	// monitor both channels and watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (smp.valid && smp.ready)
				sb.note_sample(smp.sample_in);
			if (res.valid && res.ready)
				sb.check_result(res.lowpass_out, res.highpass_out, res.bandpass_out);
			if ((smp.valid && smp.ready) || (res.valid && res.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("testbench failed");
				$finish;
			end
		end
	end

	// starts and ends at a falling edge; valid stays high into the next word
	task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			smp.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		smp.valid     <= 1'b1;
		smp.sample_in <= s;
		do @(posedge clk); while (!smp.ready);
		@(negedge clk);
	endtask

	// setup and access cycle; psel is dropped by the caller after the group
	task automatic apb_write(input logic [1:0] idx, input logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_coef(idx, v);
		@(negedge clk);
	endtask

	task automatic write_coefs(input logic [31:0] g, input logic [31:0] r2,
		input logic [31:0] d);
		apb_write(REG_CUTOFF, g);
		apb_write(REG_DAMP, r2);
		apb_write(REG_NORM, d);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// close a burst: drop valid, drain the pipeline, let the block go idle
	task automatic drain();
		smp.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// d = 1 / (1 + 2R*g + g*g), rounded, Q1.24
	function automatic logic [31:0] norm_for(input logic [31:0] g, input logic [31:0] r2);
		logic [127:0] den;
		den = (128'd1 << 48) + 128'(r2) * 128'(g) + 128'(g) * 128'(g);
		return 32'(((128'd1 << 72) + den / 2) / den);
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(
		input logic signed [SAMPLE_BITS-1:0] prev);
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return SAMPLE_BITS'($urandom);
		if (r < 70)
			return SAMPLE_BITS'(int'($urandom_range(0, 8191)) - 4096);
		if (r < 85)
			return $urandom_range(0, 1) ? S_MAX : S_MIN;
		return prev;
	endfunction

	// coefficient set for one random burst
	task automatic pick_coefs();
		logic [31:0] g, r2, d;
		int kind;
		kind = $urandom_range(0, 5);
		if (kind < 3) begin
			// tuned filter, from low to high cutoff and damping
			g  = $urandom_range(1 << 14, 1 << 26);
			r2 = $urandom_range(0, 1 << 26);
			d  = norm_for(g, r2);
		end else if (kind < 5) begin
			g  = $urandom;
			r2 = $urandom;
			d  = $urandom;
		end else begin
			g  = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
			r2 = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
			d  = $urandom_range(0, 1) ? 32'h01FF_FFFF : 32'h0;
		end
		write_coefs(g, r2, d);
	endtask

	initial begin
		logic signed [SAMPLE_BITS-1:0] defaults_set[8];
		logic signed [SAMPLE_BITS-1:0] hot_set[10];
		logic signed [SAMPLE_BITS-1:0] s;

		defaults_set = '{24'sh0, S_MAX, S_MIN, 24'sh1, -24'sh1, 24'sh555555,
			24'shAAAAAA, 24'sh0};
		hot_set = '{S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MIN, S_MAX, 24'sh0,
			S_MIN, 24'sh0};

		arst_n        = 1'b0;
		smp.valid     = 1'b0;
		smp.sample_in = '0;
		res.ready     = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		calm          = 1'b0;
		idle_cycles   = 0;
		ready_hold    = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset coefficients: g is zero, so hp follows the input
		foreach (defaults_set[i]) send_sample(defaults_set[i]);
		drain();

		// feedback sum clamps, normalizer above 1.0, everything saturates
		write_coefs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h01FF_FFFF);
		foreach (hot_set[i]) send_sample(hot_set[i]);
		drain();

		// all-zero coefficients hold the saturated integrators
		write_coefs(32'h0, 32'h0, 32'h0);
		send_sample(S_MAX);
		send_sample(S_MIN);
		send_sample(24'sh1);
		drain();

		// unity cutoff impulse response
		write_coefs(COEF_ONE, COEF_ONE, norm_for(COEF_ONE, COEF_ONE));
		send_sample(S_MAX);
		send_sample(24'sh0);
		send_sample(24'sh0);
		send_sample(24'sh0);
		drain();

		// random bursts under changing coefficients
		s = '0;
		for (int p = 0; p < PHASES; p++) begin
			calm = ($urandom_range(0, 3) == 0);
			pick_coefs();
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				s = pick_sample(s);
				send_sample(s);
			end
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
